// File: design/sap_pkg.sv
// Shared types, constants and class tables for the slab size class allocator.
// No dependencies; imported by slab_size_class_allocator.
`default_nettype none

package sap_pkg;

  localparam int ADDR_PAGES     = 16;
  localparam int DEF_POOL_PAGES = 16;
  localparam int CLASS_COUNT    = 8;
  localparam int LINK_W         = 5;

  localparam logic [LINK_W-1:0] LINK_NONE    = 5'd31;
  localparam logic [7:0]        SLOT_END     = 8'd255;
  localparam logic [11:0]       HEADER_BYTES = 12'd32;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_BAD_PTR   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_HEAD,
    S_WALK,
    S_FINDPG,
    S_THREAD,
    S_POP,
    S_POP2,
    S_FCHK,
    S_FWALK,
    S_FWAIT,
    S_FPUSH,
    S_QRY,
    S_OUT
  } state_e;

  // Slot size of class k: 16 << k.
  function automatic logic [11:0] class_size(input logic [2:0] k);
    class_size = 12'd16 << k;
  endfunction

  // Byte offset of slot zero within the page.
  function automatic logic [11:0] first_off(input logic [2:0] k);
    first_off = (k >= 3'd6) ? class_size(k) : HEADER_BYTES;
  endfunction

  // Slots per page for class k.
  function automatic logic [7:0] slot_total(input logic [2:0] k);
    logic [7:0] t;
    case (k)
      3'd0:    t = 8'd254;
      3'd1:    t = 8'd127;
      3'd2:    t = 8'd63;
      3'd3:    t = 8'd31;
      3'd4:    t = 8'd15;
      3'd5:    t = 8'd7;
      3'd6:    t = 8'd3;
      3'd7:    t = 8'd1;
      default: t = 8'd1;
    endcase
    slot_total = t;
  endfunction

endpackage

`default_nettype wire

// File: design/slab_size_class_allocator.sv
// Slab allocator over 4 KiB pool pages with eight power-of-two size classes.
// Depends on sap_pkg for codes, class tables and the state type.
//
// Usage: one request channel (cmd_i, req_size_i, addr_i with in_valid_i /
// in_ready_o) and one result channel (result_addr_o, class_bytes_o, status_o
// with out_valid_o / out_ready_i). The block takes one item at a time:
// in_ready_o is high only while it is idle, and each item gives exactly one
// result, held in registers until out_ready_i takes it.
// Path of each item from accept to result valid:
//   cmd 3 and errors found at decode go straight to the result; query and
//   bad slot on free take one check step; allocate from a listed slab walks
//   each full slab on the class list; allocate on a fresh page walks those,
//   then threads the freelist, one slot link write per cycle for each slot
//   of the class (1 to 254)
//   free: pushes at once when the page has no free slot, else first walks
//   the page freelist through the slot link memory to find a double free;
//   a double free ends the walk early
// A stalled receiver holds the result and the block accepts nothing.
// Reset clears the page in-use bits and the class list heads; the slot link
// memory and per-page tables need no clearing pass, they are written when a
// page is threaded before they are read.
`default_nettype none

module slab_size_class_allocator #(
  parameter int POOL_PAGES = sap_pkg::DEF_POOL_PAGES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [15:0] req_size_i,
  input  wire logic [15:0] addr_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      result_addr_o,
  output logic [11:0]      class_bytes_o,
  output logic [2:0]       status_o
);
  import sap_pkg::*;

  localparam int USABLE = (POOL_PAGES < ADDR_PAGES) ? POOL_PAGES : ADDR_PAGES;
  localparam int PG_W   = (USABLE > 1) ? $clog2(USABLE) : 1;
  localparam int MA_W   = PG_W + 8;
  localparam logic [LINK_W-1:0] USABLE_L = LINK_W'(USABLE);

  state_e state_q, state_d;

  logic [1:0]  cmd_q;
  logic [15:0] req_q, addr_q;
  logic [PG_W-1:0] cur_q, cur_d;
  logic [2:0]  k_q, k_d;
  logic [7:0]  idx_q, idx_d, j_q, j_d, n_q, n_d, cnt_q, cnt_d;
  logic [15:0] res_addr_q, res_addr_d;
  logic [11:0] res_class_q, res_class_d;
  status_e     res_status_q, res_status_d;

  // per-page tables and list heads
  logic [USABLE-1:0] in_use_q;
  logic [LINK_W-1:0] head_q [CLASS_COUNT];
  logic [2:0]        pclass_q [USABLE];
  logic [7:0]        pfree_q  [USABLE];
  logic [7:0]        pfirst_q [USABLE];
  logic [LINK_W-1:0] pnext_q  [USABLE];
  logic [LINK_W-1:0] pprev_q  [USABLE];

  // slot link memory
  logic [7:0] slot_mem [USABLE*256];
  logic       mem_we;
  logic [MA_W-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata_q;

  // decode helpers
  logic [3:0]  pg_a;
  logic        pg_ok;
  logic [2:0]  k_req;
  logic        req_big;
  logic [LINK_W-1:0] head;
  logic        head_ok;
  logic [7:0]  cur_free, cur_first;
  logic [LINK_W-1:0] cur_next, cur_prev;
  logic        next_ok, prev_ok;
  logic [2:0]  cur_cls;
  logic [PG_W-1:0] fp;
  logic        fp_none;
  logic [11:0] f_off, f_first, f_csz, f_diff;
  logic [7:0]  f_idx, f_tot;
  logic        f_bad;
  logic        thr_last;
  logic [15:0] pop_addr;
  logic        fp_last;

  assign pg_a    = addr_q[15:12];
  assign pg_ok   = ({1'b0, pg_a} < USABLE_L) && in_use_q[pg_a[PG_W-1:0]];
  assign head    = head_q[k_q];
  assign head_ok = head < USABLE_L;
  assign cur_free  = pfree_q[cur_q];
  assign cur_first = pfirst_q[cur_q];
  assign cur_next  = pnext_q[cur_q];
  assign cur_prev  = pprev_q[cur_q];
  assign cur_cls   = pclass_q[cur_q];
  assign next_ok   = cur_next < USABLE_L;
  assign prev_ok   = cur_prev < USABLE_L;

  always_comb begin
    k_req   = 3'd7;
    req_big = 1'b1;
    for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
      if (req_q <= {4'b0, class_size(3'(i))}) begin
        k_req   = 3'(i);
        req_big = 1'b0;
      end
    end
  end

  // lowest unused page
  always_comb begin
    fp      = '0;
    fp_none = 1'b1;
    for (int i = USABLE - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        fp      = PG_W'(i);
        fp_none = 1'b0;
      end
    end
  end

  assign f_off   = addr_q[11:0];
  assign f_first = first_off(cur_cls);
  assign f_csz   = class_size(cur_cls);
  assign f_tot   = slot_total(cur_cls);
  assign f_diff  = f_off - f_first;
  assign f_idx   = 8'(f_diff >> ({1'b0, cur_cls} + 4'd4));
  assign f_bad   = (f_off < f_first) || ((f_diff & (f_csz - 12'd1)) != 12'd0)
                   || (f_idx >= f_tot);

  assign thr_last = (cnt_q + 8'd1) == slot_total(k_q);
  assign fp_last  = (cur_free + 8'd1) == slot_total(k_q);
  assign pop_addr = (16'(cur_q) << 12) + {4'b0, first_off(k_q)}
                    + (16'(idx_q) << ({1'b0, k_q} + 4'd4));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (cmd_q)
          CMD_ALLOC: state_d = (req_q == 16'd0 || req_big) ? S_OUT : S_HEAD;
          CMD_FREE:  state_d = pg_ok ? S_FCHK : S_OUT;
          CMD_QUERY: state_d = pg_ok ? S_QRY : S_OUT;
          default:   state_d = S_OUT;
        endcase
      end
      S_HEAD:   state_d = head_ok ? S_WALK : S_FINDPG;
      S_WALK: begin
        if (cur_free != 8'd0) state_d = S_POP;
        else if (!next_ok)    state_d = S_FINDPG;
      end
      S_FINDPG: state_d = fp_none ? S_OUT : S_THREAD;
      S_THREAD: if (thr_last) state_d = S_POP;
      S_POP:    state_d = S_POP2;
      S_POP2:   state_d = S_OUT;
      S_FCHK: begin
        if (f_bad)                  state_d = S_OUT;
        else if (cur_free == 8'd0)  state_d = S_FPUSH;
        else                        state_d = S_FWALK;
      end
      S_FWALK: begin
        if (n_q == cur_free)  state_d = S_FPUSH;
        else if (j_q == idx_q) state_d = S_OUT;
        else                   state_d = S_FWAIT;
      end
      S_FWAIT:  state_d = S_FWALK;
      S_FPUSH:  state_d = S_OUT;
      S_QRY:    state_d = S_OUT;
      S_OUT:    if (out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE:  in_ready_o  = 1'b1;
      S_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign result_addr_o = res_addr_q;
  assign class_bytes_o = res_class_q;
  assign status_o      = res_status_q;

  // datapath next values
  always_comb begin
    cur_d        = cur_q;
    k_d          = k_q;
    idx_d        = idx_q;
    j_d          = j_q;
    n_d          = n_q;
    cnt_d        = cnt_q;
    res_addr_d   = res_addr_q;
    res_class_d  = res_class_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = {cur_q, cnt_q};
    mem_wdata    = thr_last ? SLOT_END : cnt_q + 8'd1;
    mem_raddr    = {cur_q, j_q};
    case (state_q)
      S_DECODE: begin
        res_addr_d   = '0;
        res_class_d  = '0;
        res_status_d = ST_OK;
        k_d          = k_req;
        cur_d        = pg_a[PG_W-1:0];
        case (cmd_q)
          CMD_ALLOC: begin
            if (req_q == 16'd0) res_status_d = ST_ZERO;
            else if (req_big)   res_status_d = ST_TOO_LARGE;
          end
          CMD_FREE, CMD_QUERY: if (!pg_ok) res_status_d = ST_BAD_PTR;
          default: ;
        endcase
      end
      S_HEAD:   cur_d = head[PG_W-1:0];
      S_WALK:   if (cur_free == 8'd0 && next_ok) cur_d = cur_next[PG_W-1:0];
      S_FINDPG: begin
        cur_d = fp;
        cnt_d = '0;
        if (fp_none) res_status_d = ST_EXHAUSTED;
      end
      S_THREAD: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + 8'd1;
      end
      S_POP: begin
        idx_d     = cur_first;
        mem_raddr = {cur_q, cur_first};
      end
      S_POP2: begin
        res_addr_d  = pop_addr;
        res_class_d = class_size(k_q);
      end
      S_FCHK: begin
        k_d   = cur_cls;
        idx_d = f_idx;
        j_d   = cur_first;
        n_d   = '0;
        if (f_bad) res_status_d = ST_BAD_PTR;
      end
      S_FWALK: begin
        n_d = n_q + 8'd1;
        if (n_q != cur_free && j_q == idx_q) res_status_d = ST_BAD_PTR;
      end
      S_FWAIT:  j_d = mem_rdata_q;
      S_FPUSH: begin
        mem_we    = 1'b1;
        mem_waddr = {cur_q, idx_q};
        mem_wdata = cur_first;
      end
      S_QRY:    res_class_d = class_size(cur_cls);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q  <= cmd_i;
      req_q  <= req_size_i;
      addr_q <= addr_i;
    end
    cur_q        <= cur_d;
    k_q          <= k_d;
    idx_q        <= idx_d;
    j_q          <= j_d;
    n_q          <= n_d;
    cnt_q        <= cnt_d;
    res_addr_q   <= res_addr_d;
    res_class_q  <= res_class_d;
    res_status_q <= res_status_d;
  end

  // in-use bits and list heads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      for (int i = 0; i < CLASS_COUNT; i++) head_q[i] <= LINK_NONE;
    end else begin
      case (state_q)
        S_FINDPG: begin
          if (!fp_none) begin
            in_use_q[fp] <= 1'b1;
            head_q[k_q]  <= LINK_W'(fp);
          end
        end
        S_FPUSH: begin
          if (fp_last) begin
            in_use_q[cur_q] <= 1'b0;
            if (!prev_ok) head_q[k_q] <= cur_next;
          end
        end
        default: ;
      endcase
    end
  end

  // per-page tables
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_FINDPG: begin
        if (!fp_none) begin
          pclass_q[fp] <= k_q;
          pfree_q[fp]  <= slot_total(k_q);
          pfirst_q[fp] <= '0;
          pnext_q[fp]  <= head;
          pprev_q[fp]  <= LINK_NONE;
          if (head_ok) pprev_q[head[PG_W-1:0]] <= LINK_W'(fp);
        end
      end
      S_POP2: begin
        pfirst_q[cur_q] <= mem_rdata_q;
        pfree_q[cur_q]  <= cur_free - 8'd1;
      end
      S_FPUSH: begin
        pfirst_q[cur_q] <= idx_q;
        pfree_q[cur_q]  <= cur_free + 8'd1;
        if (fp_last) begin
          if (prev_ok) pnext_q[cur_prev[PG_W-1:0]] <= cur_next;
          if (next_ok) pprev_q[cur_next[PG_W-1:0]] <= cur_prev;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= slot_mem[mem_raddr];
  end

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready and result valid together");
  a_thread_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_THREAD |-> in_use_q[cur_q])
    else $error("threading a page not marked in use");
  a_alloc_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP2) |=> (res_class_q != 12'd0 && res_status_q == ST_OK))
    else $error("allocation result lacks class size");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FWALK |-> n_q <= cur_free)
    else $error("freelist walk ran past free count");
`endif

endmodule

`default_nettype wire
